FILE: src/tgc_pkg.sv
// Shared types, codes and constants of the touch gesture classifier.
package tgc_pkg;

  // Button table size and derived index widths.
  localparam int MAX_BUTTONS = 16;
  localparam int IDX_W       = $clog2(MAX_BUTTONS);
  localparam int CNT_W       = $clog2(MAX_BUTTONS + 1);

  // Coordinate width of the event and rectangle fields.
  localparam int COORD_W = 12;

  // Configuration register indexes.
  localparam logic CFG_CLICK_RADIUS = 1'b0;
  localparam logic CFG_BUTTON_COUNT = 1'b1;

  // Request kinds.
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_RECT  = 1'b1;

  // Input event types and codes.
  localparam logic [4:0] EV_KEY    = 5'd1;
  localparam logic [4:0] EV_ABS    = 5'd3;
  localparam logic [9:0] ABS_X     = 10'd0;
  localparam logic [9:0] ABS_Y     = 10'd1;
  localparam logic [9:0] KEY_TOUCH = 10'd330;

  // Gesture codes.
  localparam logic [2:0] GEST_TAP   = 3'd0;
  localparam logic [2:0] GEST_LEFT  = 3'd1;
  localparam logic [2:0] GEST_RIGHT = 3'd2;
  localparam logic [2:0] GEST_UP    = 3'd3;
  localparam logic [2:0] GEST_DOWN  = 3'd4;

  // Scaling: x*800/1024 is x*25/32; y*480/600 is (4*y)/5, taken as a
  // multiply by a reciprocal that is exact for 4*y below 16384.
  localparam int TX_MUL    = 25;
  localparam int TX_SHIFT  = 5;
  localparam int TY_RECIP  = 13108;
  localparam int TY_SHIFT  = 16;
  localparam int TX_PROD_W = COORD_W + 5;
  localparam int TY_PROD_W = COORD_W + 2 + 14;

  // Reset values of the configuration registers.
  localparam logic [11:0] CLICK_RADIUS_RST = 12'd50;
  localparam logic [4:0]  BUTTON_COUNT_RST = 5'd0;

  // One stored button rectangle.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_DECIDE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: src/touch_gesture_classifier.sv
// Top level of the touch gesture classifier with its button hit test.
// Axis events and rectangle writes are taken while the sequencer is idle.
// A touch release passes the difference and decision states to a result for a
// swipe or for a tap with no buttons in use; a tap with n buttons in use (n from
// 1 to 16) then walks them, one entry a cycle through the registered read port.
// Synchronous active-low reset sets the control, stroke and config registers; the
// datapath and button table hold no reset; the table is valid only where written.
module touch_gesture_classifier import tgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [11:0]          cfg_wdata,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [4:0]           in_ev_type,
  input  logic [9:0]           in_ev_code,
  input  logic [11:0]          in_ev_value,
  input  logic [3:0]           in_slot,
  input  logic [11:0]          in_rect_left,
  input  logic [11:0]          in_rect_top,
  input  logic [11:0]          in_rect_right,
  input  logic [11:0]          in_rect_bottom,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_gesture,
  output logic [11:0]          out_tap_x,
  output logic [11:0]          out_tap_y,
  output logic                 out_hit,
  output logic [3:0]           out_button
);

  // Configuration registers.
  logic [11:0] click_radius_r;
  logic [4:0]  button_count_r;

  // Stroke state.
  logic [COORD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic               x_lat_r, y_lat_r;

  // Sequencer.
  state_t state_r, state_nxt;

  // Difference stage results.
  logic [COORD_W-1:0]   adx_r, ady_r;
  logic                 dx_pos_r, dy_pos_r;
  logic [TX_PROD_W-1:0] tx_prod_r;
  logic [TY_PROD_W-1:0] ty_prod_r;

  // Tap point and result registers.
  logic [COORD_W-1:0] tx_r, ty_r;
  logic [2:0]         res_gest_r;
  logic               res_hit_r;
  logic [IDX_W-1:0]   res_btn_r;

  // Table walk.
  rect_t              mem [MAX_BUTTONS];
  rect_t              rd_data_r;
  logic [CNT_W-1:0]   idx_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r;

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_gesture_r;
  logic [11:0] out_tap_x_r, out_tap_y_r;
  logic        out_hit_r;
  logic [3:0]  out_button_r;

  // Control decoded from the state.
  logic in_stall_c, load_out_c, scan_c;

  // Accepted item decode.
  logic in_acc, is_rect, is_x, is_y, is_release;

  assign in_acc     = in_valid && !in_stall_c;
  assign is_rect    = in_req_type == REQ_RECT;
  assign is_x       = !is_rect && in_ev_type == EV_ABS && in_ev_code == ABS_X;
  assign is_y       = !is_rect && in_ev_type == EV_ABS && in_ev_code == ABS_Y;
  assign is_release = !is_rect && in_ev_type == EV_KEY && in_ev_code == KEY_TOUCH &&
                      in_ev_value == '0;

  // Number of entries to walk, held to the table size.
  logic [CNT_W-1:0] n_sat;
  always_comb begin
    if (int'(button_count_r) > MAX_BUTTONS) begin
      n_sat = CNT_W'(MAX_BUTTONS);
    end else begin
      n_sat = CNT_W'(button_count_r);
    end
  end

  // Tap test and rectangle match.
  logic is_tap, match, last_entry;
  assign is_tap     = adx_r <= click_radius_r && ady_r <= click_radius_r;
  assign match      = tx_r >= rd_data_r.left && tx_r <= rd_data_r.right &&
                      ty_r >= rd_data_r.top  && ty_r <= rd_data_r.bottom;
  assign last_entry = CNT_W'(rd_idx_r) + CNT_W'(1) == n_sat;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_release) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (is_tap && n_sat != '0) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (rd_vld_r && (match || last_entry)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Controls from the state.
  always_comb begin
    in_stall_c = 1'b1;
    load_out_c = 1'b0;
    scan_c     = 1'b0;
    unique case (state_r)
      S_IDLE:   in_stall_c = 1'b0;
      S_DIFF:   ;
      S_DECIDE: ;
      S_SCAN:   scan_c = 1'b1;
      S_DONE:   load_out_c = !out_valid_r || !out_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_radius_r <= CLICK_RADIUS_RST;
      button_count_r <= BUTTON_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLICK_RADIUS: click_radius_r <= cfg_wdata;
        CFG_BUTTON_COUNT: button_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Stroke latches: first coordinate latched, last tracked, all cleared
  // once the release has been captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      x_lat_r   <= 1'b0;
      y_lat_r   <= 1'b0;
    end else if (state_r == S_DIFF) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      x_lat_r   <= 1'b0;
      y_lat_r   <= 1'b0;
    end else if (in_acc && is_x) begin
      if (!x_lat_r) begin
        start_x_r <= in_ev_value;
        x_lat_r   <= 1'b1;
      end
      end_x_r <= in_ev_value;
    end else if (in_acc && is_y) begin
      if (!y_lat_r) begin
        start_y_r <= in_ev_value;
        y_lat_r   <= 1'b1;
      end
      end_y_r <= in_ev_value;
    end
  end

  // Difference stage: magnitudes, signs and the two scaling products.
  always_ff @(posedge clk) begin
    if (state_r == S_DIFF) begin
      adx_r     <= (start_x_r >= end_x_r) ? start_x_r - end_x_r : end_x_r - start_x_r;
      ady_r     <= (start_y_r >= end_y_r) ? start_y_r - end_y_r : end_y_r - start_y_r;
      dx_pos_r  <= start_x_r > end_x_r;
      dy_pos_r  <= start_y_r > end_y_r;
      tx_prod_r <= TX_PROD_W'(start_x_r) * TX_PROD_W'(TX_MUL);
      ty_prod_r <= TY_PROD_W'({start_y_r, 2'b00}) * TY_PROD_W'(TY_RECIP);
    end
  end

  // Decision and walk results.
  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      res_hit_r <= 1'b0;
      res_btn_r <= '0;
      if (is_tap) begin
        res_gest_r <= GEST_TAP;
        tx_r       <= tx_prod_r[TX_SHIFT +: COORD_W];
        ty_r       <= ty_prod_r[TY_SHIFT +: COORD_W];
      end else begin
        tx_r <= '0;
        ty_r <= '0;
        if (adx_r > ady_r) begin
          res_gest_r <= dx_pos_r ? GEST_LEFT : GEST_RIGHT;
        end else begin
          res_gest_r <= dy_pos_r ? GEST_UP : GEST_DOWN;
        end
      end
    end else if (scan_c && rd_vld_r && match) begin
      res_hit_r <= 1'b1;
      res_btn_r <= rd_idx_r;
    end
  end

  // Button table: written by rectangle items, read one entry a cycle.
  always_ff @(posedge clk) begin
    if (in_acc && is_rect && int'(in_slot) < MAX_BUTTONS) begin
      mem[IDX_W'(in_slot)] <= '{left:   in_rect_left,
                                top:    in_rect_top,
                                right:  in_rect_right,
                                bottom: in_rect_bottom};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
    rd_idx_r  <= idx_r[IDX_W-1:0];
  end

  // Walk counter and read-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_c && idx_r < n_sat && !(rd_vld_r && (match || last_entry));
      if (scan_c) begin
        idx_r <= idx_r + CNT_W'(1);
      end else begin
        idx_r <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out_c) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_c) begin
      out_gesture_r <= res_gest_r;
      out_tap_x_r   <= tx_r;
      out_tap_y_r   <= ty_r;
      out_hit_r     <= res_hit_r;
      out_button_r  <= 4'(res_btn_r);
    end
  end

  assign in_stall    = in_stall_c;
  assign out_valid   = out_valid_r;
  assign out_gesture = out_gesture_r;
  assign out_tap_x   = out_tap_x_r;
  assign out_tap_y   = out_tap_y_r;
  assign out_hit     = out_hit_r;
  assign out_button  = out_button_r;

endmodule

FILE: src/tgc_checker.sv
// Port-level checker for the touch gesture classifier, bound to the top level.
module tgc_checker import tgc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_gesture,
  input logic [11:0] out_tap_x,
  input logic [11:0] out_tap_y,
  input logic        out_hit,
  input logic [3:0]  out_button
);

  // A stalled result item stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gesture) &&
    $stable(out_tap_x) && $stable(out_tap_y) && $stable(out_hit) && $stable(out_button))
    else $error("result item changed while stalled");

  // Swipes carry no tap point and no button hit.
  a_swipe_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gesture != GEST_TAP |->
    out_tap_x == '0 && out_tap_y == '0 && !out_hit)
    else $error("swipe item with tap data");

  // A miss reports button zero.
  a_miss_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_button == '0)
    else $error("button index without a hit");

  // Scaled tap point stays within the scaled coordinate range.
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gesture == GEST_TAP |-> out_tap_x <= 12'd3199 && out_tap_y <= 12'd3276)
    else $error("tap point out of range");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench of the touch gesture classifier: directed strokes, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tgc_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 12;
  // Long enough for a tap that walks the whole table, with margin to spare.
  localparam int SETTLE_CYCLES = 32;
  // Far above the slowest correct run of about two thousand items.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  // Screen scaling of a tap: raw 1024x600 onto 800x480.
  localparam int SCREEN_W  = 800;
  localparam int RAW_W     = 1024;
  localparam int SCREEN_H  = 480;
  localparam int RAW_H     = 600;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int MAX_TAP_X = COORD_MAX * SCREEN_W / RAW_W;
  localparam int MAX_TAP_Y = COORD_MAX * SCREEN_H / RAW_H;

  // One item as offered on the input channel.
  typedef struct {
    logic               req_type;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic [COORD_W-1:0] ev_value;
    logic [IDX_W-1:0]   slot;
    rect_t              rect;
  } touch_item_t;

  // One gesture result.
  typedef struct packed {
    logic [2:0]         gesture;
    logic [COORD_W-1:0] tap_x;
    logic [COORD_W-1:0] tap_y;
    logic               hit;
    logic [IDX_W-1:0]   button;
  } gesture_res_t;

  // Stroke tracker and button table of the block, with the gestures still owed by it.
  class gesture_scoreboard;
    logic [11:0]          radius;
    logic [4:0]           count;
    logic [COORD_W-1:0]   sx, sy, ex, ey;
    bit                   x_held, y_held;
    rect_t                buttons [MAX_BUTTONS];
    bit [MAX_BUTTONS-1:0] written;
    gesture_res_t         pending_gestures [$];
    int                   errors, checked, taps, hits, swipes;

    function new();
      radius  = CLICK_RADIUS_RST;
      count   = BUTTON_COUNT_RST;
      sx      = '0;
      sy      = '0;
      ex      = '0;
      ey      = '0;
      x_held  = 1'b0;
      y_held  = 1'b0;
      written = '0;
      foreach (buttons[i]) buttons[i] = '0;
      errors  = 0;
      checked = 0;
      taps    = 0;
      hits    = 0;
      swipes  = 0;
    endfunction

    function void set_reg(logic idx, logic [11:0] value);
      if (idx == CFG_CLICK_RADIUS) begin
        radius = value;
      end else begin
        count = value[4:0];
      end
    endfunction

    // Number of table entries written without a gap from entry zero.
    function int written_run();
      int n;
      n = 0;
      while (n < MAX_BUTTONS && written[n]) n++;
      return n;
    endfunction

    // Advance the stroke by one accepted item; a touch release queues its gesture.
    // Returns 1 when the block acts on the item.
    function bit take_item(touch_item_t it);
      int           dx, dy, adx, ady, limit;
      gesture_res_t res;
      if (it.req_type == REQ_RECT) begin
        buttons[it.slot] = it.rect;
        written[it.slot] = 1'b1;
        return 1'b1;
      end
      if (it.ev_type == EV_ABS && it.ev_code == ABS_X) begin
        if (!x_held) begin
          sx     = it.ev_value;
          x_held = 1'b1;
        end
        ex = it.ev_value;
        return 1'b1;
      end
      if (it.ev_type == EV_ABS && it.ev_code == ABS_Y) begin
        if (!y_held) begin
          sy     = it.ev_value;
          y_held = 1'b1;
        end
        ey = it.ev_value;
        return 1'b1;
      end
      if (!(it.ev_type == EV_KEY && it.ev_code == KEY_TOUCH && it.ev_value == '0)) return 1'b0;

      // Touch release: compare the start and end points of the stroke.
      dx  = int'(sx) - int'(ex);
      dy  = int'(sy) - int'(ey);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      res = '0;
      if (adx <= int'(radius) && ady <= int'(radius)) begin
        res.gesture = GEST_TAP;
        res.tap_x   = COORD_W'(int'(sx) * SCREEN_W / RAW_W);
        res.tap_y   = COORD_W'(int'(sy) * SCREEN_H / RAW_H);
        limit = (int'(count) > MAX_BUTTONS) ? MAX_BUTTONS : int'(count);
        for (int i = 0; i < limit; i++) begin
          if (res.tap_x >= buttons[i].left && res.tap_x <= buttons[i].right &&
              res.tap_y >= buttons[i].top && res.tap_y <= buttons[i].bottom) begin
            res.hit    = 1'b1;
            res.button = IDX_W'(i);
            break;
          end
        end
        taps++;
        if (res.hit) hits++;
      end else begin
        if (adx > ady) begin
          res.gesture = (dx > 0) ? GEST_LEFT : GEST_RIGHT;
        end else begin
          res.gesture = (dy > 0) ? GEST_UP : GEST_DOWN;
        end
        swipes++;
      end
      pending_gestures.push_back(res);

      // Every release ends the stroke.
      sx     = '0;
      sy     = '0;
      ex     = '0;
      ey     = '0;
      x_held = 1'b0;
      y_held = 1'b0;
      return 1'b1;
    endfunction

    // Compare one accepted result with the oldest gesture owed.
    function void check_gesture(gesture_res_t got);
      gesture_res_t want;
      if (pending_gestures.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: gesture %0d tap (%0d,%0d) hit %0d button %0d",
                   $realtime, got.gesture, got.tap_x, got.tap_y, got.hit, got.button);
        end
        return;
      end
      want = pending_gestures.pop_front();
      checked++;
      if (got.gesture !== want.gesture || got.tap_x !== want.tap_x ||
          got.tap_y !== want.tap_y || got.hit !== want.hit || got.button !== want.button) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] result %0d: expected gesture %0d tap (%0d,%0d) hit %0d button %0d",
                   $realtime, checked, want.gesture, want.tap_x, want.tap_y, want.hit,
                   want.button);
          $display("[%0t] result %0d:   actual gesture %0d tap (%0d,%0d) hit %0d button %0d",
                   $realtime, checked, got.gesture, got.tap_x, got.tap_y, got.hit,
                   got.button);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [11:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [4:0]         in_ev_type;
  logic [9:0]         in_ev_code;
  logic [11:0]        in_ev_value;
  logic [3:0]         in_slot;
  logic [11:0]        in_rect_left;
  logic [11:0]        in_rect_top;
  logic [11:0]        in_rect_right;
  logic [11:0]        in_rect_bottom;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_gesture;
  logic [11:0]        out_tap_x;
  logic [11:0]        out_tap_y;
  logic               out_hit;
  logic [3:0]         out_button;

  gesture_scoreboard  sb;
  bit                 quiet = 1'b0;
  int                 rx_hold = 0;
  int                 sent_items = 0;
  int                 acted_items = 0;
  int                 phases = 0;
  int unsigned        cycle_count = 0;

  touch_gesture_classifier dut (.*);

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every result the bench accepts.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_gesture({out_gesture, out_tap_x, out_tap_y, out_hit, out_button});
    end
  end

  // Result side: random stall bursts, one long hold on request, none once quiet.
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        n         = rx_hold;
        rx_hold   = 0;
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else begin
        n         = $urandom_range(1, 16);
        out_stall = ($urandom_range(0, 2) == 0);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Random item with every field random; the kind is steered towards near misses.
  function automatic touch_item_t noise_item();
    touch_item_t it;
    it.req_type = 1'($urandom);
    it.ev_type  = 5'($urandom);
    it.ev_code  = 10'($urandom);
    it.ev_value = COORD_W'($urandom);
    it.slot     = IDX_W'($urandom);
    it.rect     = 48'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        it.req_type = REQ_EVENT;
        it.ev_type  = EV_ABS;
      end
      2: begin
        it.req_type = REQ_EVENT;
        it.ev_type  = EV_KEY;
      end
      default: it.req_type = REQ_EVENT;
    endcase
    return it;
  endfunction

  // Input event; the rectangle fields carry random values that the block ignores.
  function automatic touch_item_t touch_event(logic [4:0] typ, logic [9:0] code,
                                              logic [COORD_W-1:0] value);
    touch_item_t it;
    it          = noise_item();
    it.req_type = REQ_EVENT;
    it.ev_type  = typ;
    it.ev_code  = code;
    it.ev_value = value;
    return it;
  endfunction

  // Button rectangle write; the event fields carry random values.
  function automatic touch_item_t rect_write(logic [IDX_W-1:0] slot, rect_t r);
    touch_item_t it;
    it          = noise_item();
    it.req_type = REQ_RECT;
    it.slot     = slot;
    it.rect     = r;
    return it;
  endfunction

  // Mostly on-screen rectangles, some single points, some fully random (often inverted).
  function automatic rect_t random_rect();
    rect_t r;
    case ($urandom_range(0, 3))
      0: r = 48'({$urandom, $urandom});
      1: begin
        r.left   = COORD_W'($urandom_range(0, SCREEN_W));
        r.top    = COORD_W'($urandom_range(0, SCREEN_H));
        r.right  = r.left;
        r.bottom = r.top;
      end
      default: begin
        r.left   = COORD_W'($urandom_range(0, SCREEN_W - 1));
        r.top    = COORD_W'($urandom_range(0, SCREEN_H - 1));
        r.right  = r.left + COORD_W'($urandom_range(0, 320));
        r.bottom = r.top + COORD_W'($urandom_range(0, 200));
      end
    endcase
    return r;
  endfunction

  // Offer one item, after an optional gap, and hold it until the block takes it.
  task automatic offer(input touch_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_req_type    = it.req_type;
    in_ev_type     = it.ev_type;
    in_ev_code     = it.ev_code;
    in_ev_value    = it.ev_value;
    in_slot        = it.slot;
    in_rect_left   = it.rect.left;
    in_rect_top    = it.rect.top;
    in_rect_right  = it.rect.right;
    in_rect_bottom = it.rect.bottom;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.take_item(it)) acted_items++;
    sent_items++;
    @(negedge clk);
  endtask

  // Stop offering until every gesture owed has arrived and the block has settled.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_gestures.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_reg(idx, value);
  endtask

  // New register setting, written once the block is idle.
  task automatic start_phase(input logic [11:0] radius, input logic [4:0] count);
    drain();
    write_reg(CFG_CLICK_RADIUS, radius);
    write_reg(CFG_BUTTON_COUNT, 12'(count));
    phases++;
  endtask

  // Write every table entry not yet written, so any button count becomes legal.
  task automatic fill_table();
    for (int s = 0; s < MAX_BUTTONS; s++) begin
      if (!sb.written[s]) offer(rect_write(IDX_W'(s), random_rect()));
    end
  endtask

  // One stroke of axis events closed by a release, sometimes with noise mixed in.
  task automatic send_stroke();
    int    x0, y0, spread, steps, v, t;
    bit    on_x, x_seen, y_seen;
    rect_t r;
    // Some taps aim at a corner of a stored rectangle to land on its inclusive bounds.
    if ($urandom_range(0, 3) == 0) begin
      r  = sb.buttons[$urandom_range(0, MAX_BUTTONS - 1)];
      t  = $urandom_range(0, 1) ? int'(r.left) : int'(r.right);
      if (t > MAX_TAP_X) t = MAX_TAP_X;
      x0 = (t * RAW_W + SCREEN_W - 1) / SCREEN_W;
      t  = $urandom_range(0, 1) ? int'(r.top) : int'(r.bottom);
      if (t > MAX_TAP_Y) t = MAX_TAP_Y;
      y0 = (t * RAW_H + SCREEN_H - 1) / SCREEN_H;
    end else begin
      x0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, RAW_W - 1);
      y0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, RAW_H - 1);
    end
    spread = $urandom_range(0, 1) ? int'(sb.radius) + 2 : COORD_MAX;
    steps  = $urandom_range(1, 6);
    x_seen = 1'b0;
    y_seen = 1'b0;
    for (int k = 0; k < steps; k++) begin
      on_x = 1'($urandom);
      // The first event on an axis carries the start point itself.
      if (on_x) begin
        v      = x_seen ? x0 + $urandom_range(0, 2 * spread) - spread : x0;
        x_seen = 1'b1;
      end else begin
        v      = y_seen ? y0 + $urandom_range(0, 2 * spread) - spread : y0;
        y_seen = 1'b1;
      end
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      if ($urandom_range(0, 9) == 0) offer(noise_item());
      offer(touch_event(EV_ABS, on_x ? ABS_X : ABS_Y, COORD_W'(v)));
    end
    if ($urandom_range(0, 9) == 0) begin
      offer(touch_event(EV_KEY, KEY_TOUCH, COORD_W'($urandom_range(1, COORD_MAX))));
    end
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
  endtask

  // Random traffic until the given number of items the block acts on has gone in.
  task automatic run_phase(input int items);
    int goal;
    goal = acted_items + items;
    while (acted_items < goal) begin
      case ($urandom_range(0, 9))
        0: offer(rect_write(IDX_W'($urandom), random_rect()));
        1: offer(noise_item());
        // A stray axis event that the next stroke inherits.
        2: offer(touch_event(EV_ABS, $urandom_range(0, 1) ? ABS_X : ABS_Y,
                             COORD_W'($urandom)));
        default: send_stroke();
      endcase
    end
  endtask

  // Main sequence.
  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_CLICK_RADIUS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_EVENT;
    in_ev_type     = '0;
    in_ev_code     = '0;
    in_ev_value    = '0;
    in_slot        = '0;
    in_rect_left   = '0;
    in_rect_top    = '0;
    in_rect_right  = '0;
    in_rect_bottom = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed strokes under the reset settings.
    // Release with nothing latched: a tap at the origin.
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    // Movement of exactly the click radius is still a tap; a press yields nothing.
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(COORD_MAX)));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(COORD_MAX - 50)));
    offer(touch_event(EV_KEY, KEY_TOUCH, COORD_W'(1)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    // Equal differences resolve to the vertical direction.
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(1000)));
    offer(touch_event(EV_ABS, ABS_Y, COORD_W'(0)));
    offer(touch_event(EV_ABS, ABS_Y, COORD_W'(100)));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(900)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    // One step past the radius, with ignored events in between: a swipe right.
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(0)));
    offer(touch_event(5'h1F, 10'h3FF, COORD_W'(COORD_MAX)));
    offer(touch_event(EV_ABS, ABS_Y + 10'd1, COORD_W'(0)));
    offer(touch_event(EV_KEY, KEY_TOUCH + 10'd1, COORD_W'(0)));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(51)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    // Full-range swipes up and left.
    offer(touch_event(EV_ABS, ABS_Y, COORD_W'(COORD_MAX)));
    offer(touch_event(EV_ABS, ABS_Y, COORD_W'(0)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(COORD_MAX)));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(0)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    // Two overlapping buttons; taps on the second one and on the first one's corner.
    offer(rect_write(IDX_W'(0), '{left: 100, top: 100, right: 200, bottom: 200}));
    offer(rect_write(IDX_W'(1), '{left: 0, top: 0, right: COORD_W'(SCREEN_W - 1),
                                  bottom: COORD_W'(SCREEN_H - 1)}));
    start_phase(CLICK_RADIUS_RST, 5'd2);
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));
    offer(touch_event(EV_ABS, ABS_X, COORD_W'(128)));
    offer(touch_event(EV_ABS, ABS_Y, COORD_W'(125)));
    offer(touch_event(EV_KEY, KEY_TOUCH, '0));

    // Random phases; the button count never reaches an unwritten entry.
    start_phase(12'd0, 5'(sb.written_run()));
    run_phase(PHASE_ITEMS);
    fill_table();
    start_phase(12'(COORD_MAX), 5'h1F);
    run_phase(PHASE_ITEMS);
    // Long hold on the result side while items keep coming.
    start_phase(CLICK_RADIUS_RST, 5'(MAX_BUTTONS));
    run_phase(PHASE_ITEMS / 2);
    rx_hold = HOLD_CYCLES;
    run_phase(PHASE_ITEMS / 2);
    // Sender pause until the block has delivered everything owed.
    start_phase(12'($urandom_range(0, 200)), 5'($urandom_range(0, 31)));
    run_phase(PHASE_ITEMS / 2);
    drain();
    run_phase(PHASE_ITEMS / 2);
    start_phase(12'd1, 5'd1);
    run_phase(PHASE_ITEMS);
    start_phase(12'd300, 5'(MAX_BUTTONS + 1));
    run_phase(PHASE_ITEMS);
    start_phase(12'($urandom_range(0, COORD_MAX)), 5'($urandom_range(0, MAX_BUTTONS)));
    run_phase(PHASE_ITEMS);
    // Last phase at full rate on both sides.
    quiet = 1'b1;
    start_phase(12'd100, 5'(MAX_BUTTONS));
    run_phase(PHASE_ITEMS);
    drain();

    $display("Offered %0d items, %0d acted on, over %0d register settings.",
             sent_items, acted_items, phases);
    $display("Checked %0d gestures: %0d taps (%0d on a button), %0d swipes; %0d mismatches.",
             sb.checked, sb.taps, sb.hits, sb.swipes, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tgc_pkg.sv
src/touch_gesture_classifier.sv
src/tgc_checker.sv
bench/tb_top.sv
